// File: rtl/mtt_pkg.sv
// Shared types and constants of the markup tag tokenizer.
package mtt_pkg;

   localparam logic [7:0] MAX_ATTRS = 8'd255;

   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   localparam logic [2:0] KIND_TEXT_CHAR  = 3'd0;
   localparam logic [2:0] KIND_TEXT_END   = 3'd1;
   localparam logic [2:0] KIND_NAME_CHAR  = 3'd2;
   localparam logic [2:0] KIND_ATTR_CHAR  = 3'd3;
   localparam logic [2:0] KIND_VALUE_CHAR = 3'd4;
   localparam logic [2:0] KIND_ATTR_END   = 3'd5;
   localparam logic [2:0] KIND_TAG_END    = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified byte as handed from the front to the back.
   typedef struct packed {
      logic [7:0] ch;
      logic [7:0] lower;
      logic       escaped;
      logic       prev_space;
      logic       is_ctrl;
      logic       is_lt;
      logic       is_gt;
      logic       is_space;
      logic       is_slash;
      logic       is_eq;
      logic       is_quote;
   } mtt_item_type;

   // One token event.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] char_out;
      logic       closing;
      logic [7:0] attr_count;
      logic       attr_overflow;
   } mtt_event_type;

endpackage

// File: rtl/markup_tag_tokenizer_top.sv
// A request's event reaches rsp through two registers in order: its queue slot, then the event register.
// Throughput: one byte per cycle while rsp_tready does not stall; the back end updates its state once per byte.
// A four-entry queue between front and back absorbs rsp_tready stalls before req_tready drops.
// Reset (synchronous, active high) empties the queue and output register and returns the
// tokenizer to its start state: outside any tag and text, no previous byte.
module markup_tag_tokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_out, [8] closing, [16:9] attr_count,
                                    // [17] attr_overflow, [23:18] zero
   output logic [2:0]  rsp_tuser    // [2:0] kind
);
   import mtt_pkg::*;

   mtt_item_type  front_item;
   mtt_item_type  head_item;
   mtt_event_type ev;
   logic          q_full;
   logic          q_not_empty;
   logic          q_pop;

   assign req_tready = !q_full;

   mtt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .item     (front_item)
   );

   mtt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && req_tready),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   mtt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (head_item),
      .item_pop   (q_pop),
      .ev_valid   (rsp_tvalid),
      .ev_ready   (rsp_tready),
      .ev         (ev)
   );

   assign rsp_tdata = {6'd0, ev.attr_overflow, ev.attr_count, ev.closing, ev.char_out};
   assign rsp_tuser = ev.kind;

endmodule

// File: rtl/mtt_front.sv
// Front end: accepts bytes, tracks the previous byte and classifies each byte.
module mtt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 in_ready,
   input  logic [7:0]           in_byte,
   output mtt_pkg::mtt_item_type item
);
   import mtt_pkg::*;

   logic [7:0] prev_byte_ff;
   logic [7:0] prev_byte_in;

   assign prev_byte_in = (in_valid && in_ready) ? in_byte : prev_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= '0;
      end else begin
         prev_byte_ff <= prev_byte_in;
      end
   end

   always_comb begin
      item.ch         = in_byte;
      item.lower      = (in_byte >= CH_UPPER_A && in_byte <= CH_UPPER_Z)
                        ? in_byte + CASE_OFFSET : in_byte;
      item.escaped    = (prev_byte_ff == CH_BSLASH);
      item.prev_space = (prev_byte_ff == CH_SPACE);
      item.is_ctrl    = (in_byte == CH_LF) || (in_byte == CH_VT) || (in_byte == CH_TAB)
                        || (in_byte == CH_CR) || (in_byte == CH_FF);
      item.is_lt      = (in_byte == CH_LT);
      item.is_gt      = (in_byte == CH_GT);
      item.is_space   = (in_byte == CH_SPACE);
      item.is_slash   = (in_byte == CH_SLASH);
      item.is_eq      = (in_byte == CH_EQ);
      item.is_quote   = (in_byte == CH_QUOTE);
   end

endmodule

// File: rtl/mtt_queue.sv
// Small FIFO of classified bytes between the front and the back.
module mtt_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mtt_pkg::mtt_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output mtt_pkg::mtt_item_type head_item
);
   import mtt_pkg::*;

   mtt_item_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/mtt_back.sv
// Back end: tokenizer state machine and the registered event output.
module mtt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  mtt_pkg::mtt_item_type item,
   output logic                  item_pop,
   output logic                  ev_valid,
   input  logic                  ev_ready,
   output mtt_pkg::mtt_event_type ev
);
   import mtt_pkg::*;

   logic in_tag_ff, in_tag_in;
   logic in_quotes_ff, in_quotes_in;
   logic in_text_ff, in_text_in;
   logic name_done_ff, name_done_in;
   logic closing_seen_ff, closing_seen_in;
   logic value_phase_ff, value_phase_in;
   logic tag_name_empty_ff, tag_name_empty_in;
   logic attr_name_nonempty_ff, attr_name_nonempty_in;
   logic text_nonempty_ff, text_nonempty_in;
   logic overflow_seen_ff, overflow_seen_in;
   logic [7:0] attr_counter_ff, attr_counter_in;
   logic ev_valid_ff, ev_valid_in;
   mtt_event_type ev_ff, ev_in;

   logic       emit;
   logic [7:0] cnt_bumped;
   logic       ovf_bumped;

   // The event register is free when empty or being drained this cycle.
   assign item_pop = item_valid && (!ev_valid_ff || ev_ready);
   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

   always_comb begin
      cnt_bumped = attr_counter_ff;
      ovf_bumped = overflow_seen_ff;
      if (attr_counter_ff < MAX_ATTRS) begin
         cnt_bumped = attr_counter_ff + 8'd1;
      end else begin
         ovf_bumped = 1'b1;
      end
   end

   always_comb begin
      in_tag_in             = in_tag_ff;
      in_quotes_in          = in_quotes_ff;
      in_text_in            = in_text_ff;
      name_done_in          = name_done_ff;
      closing_seen_in       = closing_seen_ff;
      value_phase_in        = value_phase_ff;
      tag_name_empty_in     = tag_name_empty_ff;
      attr_name_nonempty_in = attr_name_nonempty_ff;
      text_nonempty_in      = text_nonempty_ff;
      overflow_seen_in      = overflow_seen_ff;
      attr_counter_in       = attr_counter_ff;
      emit                  = 1'b0;
      ev_in                 = '0;

      if (item_pop) begin
         priority if (!in_tag_ff && !in_quotes_ff && item.is_lt && !item.escaped) begin
            in_tag_in = 1'b1;
            if (in_text_ff) begin
               if (text_nonempty_ff) begin
                  emit       = 1'b1;
                  ev_in.kind = KIND_TEXT_END;
               end
               in_text_in       = 1'b0;
               text_nonempty_in = 1'b0;
            end
         end else if (in_text_ff) begin
            if (!item.is_ctrl && (!item.is_space || !item.prev_space)) begin
               text_nonempty_in = 1'b1;
               emit             = 1'b1;
               ev_in.kind       = KIND_TEXT_CHAR;
               ev_in.char_out   = item.ch;
            end
         end else if (!in_quotes_ff && item.is_gt && !item.escaped) begin
            emit                = 1'b1;
            ev_in.kind          = KIND_TAG_END;
            ev_in.closing       = closing_seen_ff;
            ev_in.attr_count    = attr_name_nonempty_ff ? cnt_bumped : attr_counter_ff;
            ev_in.attr_overflow = attr_name_nonempty_ff ? ovf_bumped : overflow_seen_ff;
            in_text_in            = 1'b1;
            in_tag_in             = 1'b0;
            name_done_in          = 1'b0;
            closing_seen_in       = 1'b0;
            attr_counter_in       = '0;
            overflow_seen_in      = 1'b0;
            attr_name_nonempty_in = 1'b0;
            tag_name_empty_in     = 1'b1;
         end else if (in_tag_ff) begin
            priority if (!name_done_ff) begin
               priority if (item.is_space) begin
                  name_done_in = 1'b1;
               end else if (item.is_slash && tag_name_empty_ff) begin
                  closing_seen_in = 1'b1;
               end else begin
                  tag_name_empty_in = 1'b0;
                  emit              = 1'b1;
                  ev_in.kind        = KIND_NAME_CHAR;
                  ev_in.char_out    = item.lower;
               end
            end else if (item.is_space && !in_quotes_ff) begin
               attr_counter_in       = cnt_bumped;
               overflow_seen_in      = ovf_bumped;
               attr_name_nonempty_in = 1'b0;
               value_phase_in        = 1'b0;
               emit                  = 1'b1;
               ev_in.kind            = KIND_ATTR_END;
            end else if (item.is_eq && !in_quotes_ff && !item.escaped) begin
               value_phase_in = 1'b1;
            end else if (value_phase_ff) begin
               if (item.is_quote && !item.escaped) begin
                  in_quotes_in = !in_quotes_ff;
               end else begin
                  emit           = 1'b1;
                  ev_in.kind     = KIND_VALUE_CHAR;
                  ev_in.char_out = item.ch;
               end
            end else begin
               attr_name_nonempty_in = 1'b1;
               emit                  = 1'b1;
               ev_in.kind            = KIND_ATTR_CHAR;
               ev_in.char_out        = item.lower;
            end
         end else begin
            // Bytes before the first tag are dropped.
         end
      end

      if (item_pop) begin
         ev_valid_in = emit;
      end else if (ev_ready) begin
         ev_valid_in = 1'b0;
      end else begin
         ev_valid_in = ev_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff             <= 1'b0;
         in_quotes_ff          <= 1'b0;
         in_text_ff            <= 1'b0;
         name_done_ff          <= 1'b0;
         closing_seen_ff       <= 1'b0;
         value_phase_ff        <= 1'b0;
         tag_name_empty_ff     <= 1'b1;
         attr_name_nonempty_ff <= 1'b0;
         text_nonempty_ff      <= 1'b0;
         overflow_seen_ff      <= 1'b0;
         attr_counter_ff       <= '0;
         ev_valid_ff           <= 1'b0;
      end else begin
         in_tag_ff             <= in_tag_in;
         in_quotes_ff          <= in_quotes_in;
         in_text_ff            <= in_text_in;
         name_done_ff          <= name_done_in;
         closing_seen_ff       <= closing_seen_in;
         value_phase_ff        <= value_phase_in;
         tag_name_empty_ff     <= tag_name_empty_in;
         attr_name_nonempty_ff <= attr_name_nonempty_in;
         text_nonempty_ff      <= text_nonempty_in;
         overflow_seen_ff      <= overflow_seen_in;
         attr_counter_ff       <= attr_counter_in;
         ev_valid_ff           <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         ev_ff <= ev_in;
      end
   end

endmodule

// File: rtl/mtt_checker.sv
// Port-level assertions for the markup tag tokenizer and their bind.
module mtt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import mtt_pkg::*;

   // A stalled event holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // No event is left over from before reset, and the empty queue takes requests.
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("rsp valid or req not ready right after reset");

   // Only a tag end carries tag fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_TAG_END |-> rsp_tdata[17:8] == 10'd0)
      else $error("tag fields set on a non tag end event");

   // Overflow can only be flagged with a saturated count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TAG_END && rsp_tdata[17] |-> rsp_tdata[16:9] == MAX_ATTRS)
      else $error("overflow flagged below the attribute limit");

   // Events without a character carry a zero character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_TEXT_END || rsp_tuser == KIND_ATTR_END
                     || rsp_tuser == KIND_TAG_END) |-> rsp_tdata[7:0] == 8'd0)
      else $error("character set on a non character event");

endmodule

bind markup_tag_tokenizer_top mtt_checker u_mtt_checker (.*);
